/* rtl/learning_user_address_classifier_defines.svh */
// Assertion macros for the address classifier.
`ifndef LEARNING_USER_ADDRESS_CLASSIFIER_DEFINES_SVH
`define LEARNING_USER_ADDRESS_CLASSIFIER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LUAC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("luac assertion failed");
`define LUAC_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("luac assertion failed");
`else
`define LUAC_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define LUAC_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

/* rtl/luac_pkg.sv */
package luac_pkg;

    localparam int MAC_W            = 48;
    localparam int IP_W             = 32;
    localparam int ISP_REGS         = 5;
    localparam int USER_ENTRIES_DEF = 64;

    localparam logic [MAC_W-1:0] ISP_MAC_RST [ISP_REGS] = '{
        48'h0023_05e4_d142, 48'h0023_05e4_d143, 48'h0023_05e4_d144,
        48'h001b_2ba3_c1c6, 48'h001b_2ba3_c1c7
    };
    localparam logic [ISP_REGS-1:0] ISP_EN_RST = 5'b11111;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ISP_A   = 3'd0;
    localparam logic [2:0] REG_ISP_E   = 3'd4;
    localparam logic [2:0] REG_EN_MASK = 3'd5;

    localparam logic CMD_UPLOAD   = 1'b0;
    localparam logic CMD_DOWNLOAD = 1'b1;

    typedef struct packed {
        logic mac_eq;
        logic ip_eq;
    } t_cmp_res;

    typedef struct packed {
        logic rd_en;
        logic wr_mac;
        logic wr_ip;
    } t_tbl_ctl;

endpackage

/* rtl/luac_cmp.sv */
module luac_cmp (
    input  logic [luac_pkg::MAC_W-1:0] i_mac_a,
    input  logic [luac_pkg::MAC_W-1:0] i_mac_b,
    input  logic [luac_pkg::IP_W-1:0]  i_ip_a,
    input  logic [luac_pkg::IP_W-1:0]  i_ip_b,
    output luac_pkg::t_cmp_res         o_res
);
    import luac_pkg::*;

    assign o_res.mac_eq = (i_mac_a == i_mac_b);
    assign o_res.ip_eq  = (i_ip_a == i_ip_b);

endmodule

/* rtl/luac_table.sv */
module luac_table #(
    parameter int ENTRIES = luac_pkg::USER_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  luac_pkg::t_tbl_ctl             i_ctl,
    input  logic [$clog2(ENTRIES)-1:0]     i_rd_addr,
    input  logic [luac_pkg::MAC_W-1:0]     i_wr_mac,
    input  logic [luac_pkg::IP_W-1:0]      i_wr_ip,
    output logic [luac_pkg::MAC_W-1:0]     o_rd_mac,
    output logic [luac_pkg::IP_W-1:0]      o_rd_ip,
    output logic [$clog2(ENTRIES+1)-1:0]   o_mac_cnt,
    output logic [$clog2(ENTRIES+1)-1:0]   o_ip_cnt
);
    import luac_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [MAC_W-1:0] mem_mac [ENTRIES];
    logic [IP_W-1:0]  mem_ip  [ENTRIES];
    logic [CW-1:0]    r_mac_cnt, n_mac_cnt;
    logic [CW-1:0]    r_ip_cnt, n_ip_cnt;
    logic [MAC_W-1:0] r_rd_mac;
    logic [IP_W-1:0]  r_rd_ip;

    // append at the fill count; the caller only writes when there is room
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_mac) begin
            mem_mac[r_mac_cnt[AW-1:0]] <= i_wr_mac;
        end
        if (i_ctl.wr_ip) begin
            mem_ip[r_ip_cnt[AW-1:0]] <= i_wr_ip;
        end
        if (i_ctl.rd_en) begin
            r_rd_mac <= mem_mac[i_rd_addr];
            r_rd_ip  <= mem_ip[i_rd_addr];
        end
    end

    always_comb begin
        n_mac_cnt = r_mac_cnt + CW'(i_ctl.wr_mac);
        n_ip_cnt  = r_ip_cnt + CW'(i_ctl.wr_ip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_cnt <= '0;
            r_ip_cnt  <= '0;
        end else begin
            r_mac_cnt <= n_mac_cnt;
            r_ip_cnt  <= n_ip_cnt;
        end
    end

    assign o_rd_mac  = r_rd_mac;
    assign o_rd_ip   = r_rd_ip;
    assign o_mac_cnt = r_mac_cnt;
    assign o_ip_cnt  = r_ip_cnt;

endmodule

/* rtl/learning_user_address_classifier.sv */
// Packet header classifier with learned user MAC and IP tables. Each header
// word is looked up by a scan of the tables, one entry per cycle through a
// single registered memory read port and one shared compare unit; an upload
// miss then checks the five ISP gateway registers one per cycle and, on a
// match, appends the source MAC and IP. The time one header occupies the block
// grows with N, the number of learned entries, and is set by the scan loop;
// a lookup hit ends the scan early. The input is not ready while a header is
// in work; a result waits in an output register, so the next header can be
// taken before it is read. Tables start empty at reset with no clearing pass.
`include "learning_user_address_classifier_defines.svh"

module learning_user_address_classifier #(
    parameter int USER_ENTRIES = luac_pkg::USER_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // header stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // source_mac[47:0], dest_mac[95:48], source_ip[127:96], dest_ip[159:128]
    input  logic [159:0] s_axis_tdata,
    // cmd[0]
    input  logic         s_axis_tuser,
    // result stream out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // is_user[0], learned[1], table_full[2], zero[7:3]
    output logic [7:0]   m_axis_tdata
);
    import luac_pkg::*;

    localparam int AW = $clog2(USER_ENTRIES);
    localparam int CW = $clog2(USER_ENTRIES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_ISP   = 3'd2;
    localparam logic [2:0] ST_LEARN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [MAC_W-1:0]    r_isp_mac [ISP_REGS];
    logic [ISP_REGS-1:0] r_isp_en;

    logic [2:0]       r_state, n_state;
    logic             r_cmd;
    logic [MAC_W-1:0] r_smac, r_dmac;
    logic [IP_W-1:0]  r_sip, r_dip;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_rd_vld, n_rd_vld;
    logic             r_mac_ok, n_mac_ok;
    logic             r_ip_ok, n_ip_ok;
    logic [2:0]       r_isp, n_isp;
    logic             r_is_user, n_is_user;
    logic             r_learned, n_learned;
    logic             r_full, n_full;
    logic             r_out_vld, n_out_vld;
    logic [2:0]       r_out_data, n_out_data;

    logic             in_acc;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    t_tbl_ctl         tbl_ctl;
    t_cmp_res         cmp;
    logic [MAC_W-1:0] rd_mac;
    logic [IP_W-1:0]  rd_ip;
    logic [CW-1:0]    mac_cnt, ip_cnt;
    logic [MAC_W-1:0] key_mac, cmp_mac_a, cmp_mac_b;
    logic [IP_W-1:0]  key_ip;
    logic             mac_room, ip_room, scan_hit, issue;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ISP_REGS; k++) begin
                r_isp_mac[k] <= ISP_MAC_RST[k];
            end
            r_isp_en <= ISP_EN_RST;
        end else if (cfg_wr) begin
            case (cfg_idx) inside
                [REG_ISP_A:REG_ISP_E]: begin
                    r_isp_mac[cfg_idx] <= pwdata[MAC_W-1:0];
                end
                REG_EN_MASK: begin
                    r_isp_en <= pwdata[ISP_REGS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx) inside
            [REG_ISP_A:REG_ISP_E]: prdata = {16'd0, r_isp_mac[cfg_idx]};
            REG_EN_MASK:           prdata = {59'd0, r_isp_en};
            default:               prdata = '0;
        endcase
    end

    // shared datapath
    assign key_mac   = (r_cmd == CMD_DOWNLOAD) ? r_dmac : r_smac;
    assign key_ip    = (r_cmd == CMD_DOWNLOAD) ? r_dip : r_sip;
    assign cmp_mac_a = (r_state == ST_ISP) ? r_isp_mac[r_isp] : rd_mac;
    assign cmp_mac_b = (r_state == ST_ISP) ? r_dmac : key_mac;

    luac_cmp u_cmp (
        .i_mac_a (cmp_mac_a),
        .i_mac_b (cmp_mac_b),
        .i_ip_a  (rd_ip),
        .i_ip_b  (key_ip),
        .o_res   (cmp)
    );

    assign mac_room = (mac_cnt < CW'(USER_ENTRIES));
    assign ip_room  = (ip_cnt < CW'(USER_ENTRIES));
    assign issue    = (r_state == ST_SCAN) && ((r_idx < mac_cnt) || (r_idx < ip_cnt));
    assign scan_hit = r_rd_vld && ((r_mac_ok && cmp.mac_eq) || (r_ip_ok && cmp.ip_eq));

    assign tbl_ctl.rd_en  = issue;
    assign tbl_ctl.wr_mac = (r_state == ST_LEARN) && mac_room;
    assign tbl_ctl.wr_ip  = (r_state == ST_LEARN) && ip_room;

    luac_table #(
        .ENTRIES (USER_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tbl_ctl),
        .i_rd_addr (r_idx[AW-1:0]),
        .i_wr_mac  (r_smac),
        .i_wr_ip   (r_sip),
        .o_rd_mac  (rd_mac),
        .o_rd_ip   (rd_ip),
        .o_mac_cnt (mac_cnt),
        .o_ip_cnt  (ip_cnt)
    );

    // sequencer
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rd_vld   = r_rd_vld;
        n_mac_ok   = r_mac_ok;
        n_ip_ok    = r_ip_ok;
        n_isp      = r_isp;
        n_is_user  = r_is_user;
        n_learned  = r_learned;
        n_full     = r_full;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state   = ST_SCAN;
                    n_idx     = '0;
                    n_rd_vld  = 1'b0;
                    n_is_user = 1'b0;
                    n_learned = 1'b0;
                    n_full    = 1'b0;
                end
            end
            ST_SCAN: begin
                // compare the word read last cycle, issue the next address
                n_rd_vld = issue;
                n_mac_ok = (r_idx < mac_cnt);
                n_ip_ok  = (r_idx < ip_cnt);
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (scan_hit) begin
                    n_is_user = 1'b1;
                    n_state   = ST_FIN;
                end else if (!issue && !r_rd_vld) begin
                    n_isp   = '0;
                    n_state = (r_cmd == CMD_DOWNLOAD) ? ST_FIN : ST_ISP;
                end
            end
            ST_ISP: begin
                if (cmp.mac_eq && r_isp_en[r_isp]) begin
                    n_state = ST_LEARN;
                end else if (r_isp == 3'(ISP_REGS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_isp = r_isp + 3'd1;
                end
            end
            ST_LEARN: begin
                n_is_user = 1'b1;
                n_learned = mac_room || ip_room;
                n_full    = !mac_room || !ip_room;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {r_full, r_learned, r_is_user};
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_mac_ok  <= 1'b0;
            r_ip_ok   <= 1'b0;
            r_isp     <= '0;
            r_is_user <= 1'b0;
            r_learned <= 1'b0;
            r_full    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_mac_ok  <= n_mac_ok;
            r_ip_ok   <= n_ip_ok;
            r_isp     <= n_isp;
            r_is_user <= n_is_user;
            r_learned <= n_learned;
            r_full    <= n_full;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (in_acc) begin
            r_cmd  <= s_axis_tuser;
            r_smac <= s_axis_tdata[47:0];
            r_dmac <= s_axis_tdata[95:48];
            r_sip  <= s_axis_tdata[127:96];
            r_dip  <= s_axis_tdata[159:128];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out_data};

    `LUAC_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, (mac_cnt <= CW'(USER_ENTRIES)) && (ip_cnt <= CW'(USER_ENTRIES)))
    `LUAC_ASSERT_IMP(a_wr_room, i_clk, i_rst_n, tbl_ctl.wr_mac || tbl_ctl.wr_ip, r_state == ST_LEARN)
    `LUAC_ASSERT_IMP(a_learn_user, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[0] || !(m_axis_tdata[1] || m_axis_tdata[2]))
    `LUAC_ASSERT_NXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
